>>> hdl/assert_macros.svh
// Assertion macros shared by the cube face mapper RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/s2c_pkg.sv
// Package for the cube face mapper: widths, Q1.17 constants, Q17 multiply function.
// Depends on nothing.
`default_nettype none
package s2c_pkg;
   localparam int QSHIFT = 17;
   localparam int QW     = 19;                // signed Q1.17 plus guard bit
   localparam logic [17:0] QONE = 18'd131072;
   localparam int CX_W   = 9;
   localparam logic [2:0] FACE_PY = 3'd0;
   localparam logic [2:0] FACE_NY = 3'd1;
   localparam logic [2:0] FACE_PX = 3'd2;
   localparam logic [2:0] FACE_NX = 3'd3;
   localparam logic [2:0] FACE_NZ = 3'd4;
   localparam logic [2:0] FACE_PZ = 3'd5;
   localparam logic CSR_EDGE = 1'b0;
   localparam logic CSR_TILT = 1'b1;
   typedef logic signed [QW-1:0] q_type;

   // signed Q17 product of two signed values, magnitude truncated toward zero
   function automatic q_type mul_q(input q_type a, input q_type b);
      logic [QW-1:0] ua, ub;
      logic [2*QW-1:0] p;
      logic [QW-1:0] m;
      ua = a[QW-1] ? QW'(-a) : QW'(a);
      ub = b[QW-1] ? QW'(-b) : QW'(b);
      p  = ua * ub;
      m  = p[QSHIFT +: QW];
      return (a[QW-1] ^ b[QW-1]) ? q_type'(-m) : q_type'(m);
   endfunction
endpackage
`default_nettype wire

>>> hdl/sphere_to_cube_face_map.sv
// Sphere to cube face mapper. One request per cycle, no stalls.
// Pipeline from start to rsp_valid: sine, products, tilt, select, then coordinate
// product, 14 divider cells and clamp. Throughput one per cycle, set by the fully
// pipelined sine cells and the 14-cell divider row.
// Reset (synchronous, active high) clears the valid pipe and tilt, sets edge to 1024.
`default_nettype none
`include "assert_macros.svh"
module sphere_to_cube_face_map #(
   parameter int MAX_EDGE = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic signed [15:0] req_latitude,
   input  wire logic [15:0] req_longitude,
   output logic             rsp_valid,
   output logic [2:0]       rsp_face,
   output logic [11:0]      rsp_face_x,
   output logic [11:0]      rsp_face_y,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);
   import s2c_pkg::*;
   localparam int LAT = 25;
   logic [12:0] edge_ff;
   logic signed [15:0] tilt_ff;
   logic [LAT-1:0] vld_ff;
   assign busy = 1'b0;        // fully pipelined
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= 13'd1024;
         tilt_ff <= '0;
         vld_ff  <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
         if (csr_valid) begin
            unique case (csr_index)
               CSR_EDGE: edge_ff <= csr_data[12:0];
               CSR_TILT: tilt_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end
   assign rsp_valid = vld_ff[LAT-1];
   // trig for lat, lon and tilt
   q_type sl, cl, sg, cg, st, ct;
   s2c_sin u_sl (.clock(clock), .ang(req_latitude), .sin_out(sl));
   s2c_sin u_cl (.clock(clock), .ang(req_latitude + 16'd16384), .sin_out(cl));
   s2c_sin u_sg (.clock(clock), .ang(req_longitude), .sin_out(sg));
   s2c_sin u_cg (.clock(clock), .ang(req_longitude + 16'd16384), .sin_out(cg));
   s2c_sin u_st (.clock(clock), .ang(tilt_ff), .sin_out(st));
   s2c_sin u_ct (.clock(clock), .ang(tilt_ff + 16'd16384), .sin_out(ct));
   // vector
   q_type x_ff, y_ff, z_ff, st_ff, ct_ff;
   logic tz_ff;
   always_ff @(posedge clock) begin
      x_ff  <= mul_q(cl, cg);
      y_ff  <= q_type'(-mul_q(cl, sg));
      z_ff  <= sl;
      st_ff <= st;
      ct_ff <= ct;
      tz_ff <= (tilt_ff == 16'sd0);
   end
   // tilt
   q_type x2_ff, y2_ff, z2_ff;
   always_ff @(posedge clock) begin
      x2_ff <= x_ff;
      y2_ff <= tz_ff ? y_ff : q_type'(mul_q(ct_ff, y_ff) - mul_q(st_ff, z_ff));
      z2_ff <= tz_ff ? z_ff : q_type'(mul_q(st_ff, y_ff) + mul_q(ct_ff, z_ff));
   end
   // face select
   logic [17:0] fx, fy, fz;
   assign fx = 18'(x2_ff[QW-1] ? -x2_ff : x2_ff);
   assign fy = 18'(y2_ff[QW-1] ? -y2_ff : y2_ff);
   assign fz = 18'(z2_ff[QW-1] ? -z2_ff : z2_ff);
   logic [2:0] face;
   logic [17:0] m;
   q_type wx, wy;
   always_comb begin
      if (fy >= fx && fy >= fz) begin
         m = fy; wx = q_type'(-x2_ff);
         face = (y2_ff > 0) ? FACE_PY : FACE_NY;
         wy = (y2_ff > 0) ? z2_ff : q_type'(-z2_ff);
      end else if (fx >= fz) begin
         m = fx; wy = q_type'(-y2_ff);
         face = (x2_ff > 0) ? FACE_PX : FACE_NX;
         wx = (x2_ff > 0) ? z2_ff : q_type'(-z2_ff);
      end else begin
         m = fz; wy = y2_ff;
         face = (z2_ff > 0) ? FACE_PZ : FACE_NZ;
         wx = (z2_ff > 0) ? q_type'(-x2_ff) : x2_ff;
      end
   end
   logic [17:0] m_ff;
   q_type wx_ff, wy_ff;
   logic [13:0] e_ff;
   logic [2:0] face_d [0:16];
   always_ff @(posedge clock) begin
      m_ff  <= m;
      wx_ff <= wx;
      wy_ff <= wy;
      // effective edge: min(edge_length, MAX_EDGE), always below 8192
      e_ff  <= (int'(edge_ff) > MAX_EDGE) ? 14'(MAX_EDGE) : {1'b0, edge_ff};
      face_d[0] <= face;
      for (int i = 1; i <= 16; i++) face_d[i] <= face_d[i-1];
   end
   s2c_coord u_cx (.clock(clock), .e(e_ff), .m(m_ff), .w(wx_ff), .c(rsp_face_x));
   s2c_coord u_cy (.clock(clock), .e(e_ff), .m(m_ff), .w(wy_ff), .c(rsp_face_y));
   assign rsp_face = face_d[16];
   // checks
   `ASSERT_IMPL(a_face_ok, clock, reset, rsp_valid, rsp_face <= FACE_PZ, "bad face")
   `ASSERT_NEXT(a_pipe, clock, reset, start, vld_ff[0], "request lost")
   `ASSERT_IMPL(a_xclamp, clock, reset, rsp_valid && |edge_ff, 13'(rsp_face_x) < edge_ff, "clamp")
endmodule
`default_nettype wire

>>> hdl/s2c_sin.sv
// Pipelined Q1.17 sine of a 16-bit binary angle, polynomial in Horner cells.
// Depends on s2c_pkg.
`default_nettype none
module s2c_sin (
   input  wire logic          clock,
   input  wire logic [15:0]   ang,
   output s2c_pkg::q_type     sin_out
);
   import s2c_pkg::*;
   localparam int NS = 4;
   localparam logic [17:0] COEF [0:4] = '{18'd205887, 18'd84668, 18'd10445, 18'd614, 18'd21};
   logic [16:0] tq_ff [0:NS];
   logic [16:0] t2_ff [0:NS];
   logic [17:0] p_ff  [0:NS];
   logic        neg_ff [0:NS];
   logic [1:0]  sp_ff [0:NS];   // 1: one, 2: zero, 0: poly
   logic [17:0] mag_ff;
   logic        negf_ff;
   logic [13:0] r;
   logic [14:0] t;
   logic [33:0] sq;
   assign r = ang[13:0];
   assign t = ang[14] ? (15'd16384 - {1'b0, r}) : {1'b0, r};
   assign sq = {t[13:0], 3'b0} * {t[13:0], 3'b0};
   always_ff @(posedge clock) begin
      tq_ff[0]  <= {t[13:0], 3'b0};
      t2_ff[0]  <= sq[33:17];
      p_ff[0]   <= 18'd21;
      neg_ff[0] <= ang[15];
      sp_ff[0]  <= t[14] ? 2'd1 : ((t == 15'd0) ? 2'd2 : 2'd0);
   end
   for (genvar i = 0; i < 4; i++) begin : g_horner
      logic [34:0] pr;
      assign pr = p_ff[i] * t2_ff[i];
      always_ff @(posedge clock) begin
         p_ff[i+1]   <= COEF[3-i] - pr[34:17];
         tq_ff[i+1]  <= tq_ff[i];
         t2_ff[i+1]  <= t2_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         sp_ff[i+1]  <= sp_ff[i];
      end
   end
   logic [34:0] fin;
   logic [17:0] fm;
   assign fin = p_ff[4] * tq_ff[4];
   assign fm  = (fin[34:17] > QONE) ? QONE : fin[34:17];
   always_ff @(posedge clock) begin
      mag_ff  <= (sp_ff[4] == 2'd1) ? QONE : ((sp_ff[4] == 2'd2) ? 18'd0 : fm);
      negf_ff <= neg_ff[4];
   end
   assign sin_out = negf_ff ? q_type'(-{1'b0, mag_ff}) : q_type'({1'b0, mag_ff});
endmodule
`default_nettype wire

>>> hdl/s2c_div_cell.sv
// One restoring-division cell: produces one quotient bit per cycle stage.
// Depends on nothing.
`default_nettype none
module s2c_div_cell #(
   parameter int NW = 32,
   parameter int DW = 20
) (
   input  wire logic          clock,
   input  wire logic [NW-1:0] num_in,
   input  wire logic [DW-1:0] den_in,
   input  wire logic [NW-1:0] rem_in,
   output logic [NW-1:0]      num_out,
   output logic [DW-1:0]      den_out,
   output logic [NW-1:0]      rem_out
);
   logic [NW:0] trial;
   logic [NW-1:0] sh;
   assign sh    = {rem_in[NW-2:0], num_in[NW-1]};
   assign trial = {1'b0, sh} - {{(NW+1-DW){1'b0}}, den_in};
   always_ff @(posedge clock) begin
      den_out <= den_in;
      rem_out <= trial[NW] ? sh : trial[NW-1:0];
      num_out <= {num_in[NW-2:0], ~trial[NW]};
   end
endmodule
`default_nettype wire

>>> hdl/s2c_coord.sv
// Pixel coordinate floor(E*(m+w)/(2m)) clamped: chain of division cells.
// Depends on s2c_pkg and s2c_div_cell.
`default_nettype none
module s2c_coord (
   input  wire logic          clock,
   input  wire logic [13:0]   e,
   input  wire logic [17:0]   m,
   input  wire s2c_pkg::q_type w,
   output logic [11:0]        c
);
   import s2c_pkg::*;
   localparam int QB = 14;          // quotient bits, quotient <= E < 16384
   localparam int NW = 34;
   localparam int DW = 20;
   logic [NW-1:0] num_c [0:QB];
   logic [NW-1:0] rem_c [0:QB];
   logic [DW-1:0] den_c [0:QB];
   logic [13:0]   e_ff [0:QB];
   logic          z_ff [0:QB];
   logic [NW-1:0] prod_ff;
   logic [DW-1:0] den_ff;
   logic [13:0]   e0_ff;
   logic          z0_ff;
   logic [19:0]   s;
   assign s = 20'(m) + 20'(signed'(w));   // m+w in [0, 2m]
   always_ff @(posedge clock) begin
      prod_ff <= NW'(s) * NW'(e);
      den_ff  <= {1'b0, m, 1'b0};
      e0_ff   <= e;
      z0_ff   <= (m == 18'd0);
   end
   // numerator shifted so quotient lands in the low QB bits
   assign num_c[0] = prod_ff << (NW - 34 + 20);
   assign rem_c[0] = NW'(prod_ff >> 14);
   assign den_c[0] = den_ff;
   assign e_ff[0]  = e0_ff;
   assign z_ff[0]  = z0_ff;
   for (genvar i = 0; i < QB; i++) begin : g_cell
      s2c_div_cell #(.NW(NW), .DW(DW)) u_cell (
         .clock(clock), .num_in(num_c[i]), .den_in(den_c[i]), .rem_in(rem_c[i]),
         .num_out(num_c[i+1]), .den_out(den_c[i+1]), .rem_out(rem_c[i+1]));
      always_ff @(posedge clock) begin
         e_ff[i+1] <= e_ff[i];
         z_ff[i+1] <= z_ff[i];
      end
   end
   logic [13:0] q, ee, lim;
   assign ee  = e_ff[QB];
   assign q   = z_ff[QB] ? {1'b0, ee[13:1]} : num_c[QB][13:0];
   assign lim = (ee == 14'd0) ? 14'd0 : ee - 14'd1;
   logic [13:0] cc;
   assign cc = (q > lim) ? lim : q;
   always_ff @(posedge clock) c <= (cc > 14'd4095) ? 12'd4095 : cc[11:0];
endmodule
`default_nettype wire

>>> bench/sphere_to_cube_face_map_check.sv
// Watches the request and response channels of the cube face mapper and checks responses.
// Holds its own fixed-point model of the mapping; depends on s2c_pkg for face and CSR codes.
`timescale 1ns / 100ps
module sphere_to_cube_face_map_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_latitude,
   input  logic [15:0] req_longitude,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_face,
   input  logic [11:0] rsp_face_x,
   input  logic [11:0] rsp_face_y,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);
   import s2c_pkg::*;

   typedef struct packed {
      logic [2:0]  face;
      logic [11:0] col;
      logic [11:0] row;
   } pixel_type;

   localparam int DEPTH = 64;      // well above the requests in flight

   pixel_type   exp_mem [0:DEPTH-1];
   int          wr_count = 0;
   int          rd_count = 0;
   logic [12:0] edge_reg;
   logic [15:0] tilt_reg;

   assign pending = wr_count - rd_count;

   function automatic longint sine_q17(input logic [15:0] ang);
      longint unsigned t, tq, t2, p, mag;
      t = ang[14] ? 16384 - ang[13:0] : ang[13:0];
      if (t >= 16384) mag = 131072;
      else if (t == 0) mag = 0;
      else begin
         tq = t << 3;
         t2 = (tq * tq) >> 17;
         p = 21;
         p = 614 - ((p * t2) >> 17);
         p = 10445 - ((p * t2) >> 17);
         p = 84668 - ((p * t2) >> 17);
         p = 205887 - ((p * t2) >> 17);
         mag = (p * tq) >> 17;
         if (mag > 131072) mag = 131072;
      end
      return ang[15] ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint cosine_q17(input logic [15:0] ang);
      return sine_q17(ang + 16'd16384);
   endfunction

   // sign-magnitude product, truncated toward zero
   function automatic longint prod_q17(input longint a, input longint b);
      longint ua, ub, p;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = (ua * ub) >>> 17;
      return ((a < 0) != (b < 0)) ? -p : p;
   endfunction

   function automatic logic [11:0] pixel_coord(input longint e, input longint m,
                                              input longint w);
      longint c;
      c = (m > 0) ? (e * (m + w)) / (2 * m) : e / 2;
      if (c < 0) c = 0;
      if (e == 0) c = 0;
      else if (c > e - 1) c = e - 1;
      if (c > 4095) c = 4095;
      return c[11:0];
   endfunction

   function automatic pixel_type map_direction(input logic [15:0] lat, input logic [15:0] lon);
      longint cl, sl, x, y, z, ny, ct, st, e, ax, ay, az;
      pixel_type r;
      cl = cosine_q17(lat);
      sl = sine_q17(lat);
      x = prod_q17(cl, cosine_q17(lon));
      y = -prod_q17(cl, sine_q17(lon));
      z = sl;
      e = (edge_reg > 4096) ? 4096 : edge_reg;
      if (tilt_reg != 0) begin
         ct = cosine_q17(tilt_reg);
         st = sine_q17(tilt_reg);
         ny = prod_q17(ct, y) - prod_q17(st, z);
         z = prod_q17(st, y) + prod_q17(ct, z);
         y = ny;
      end
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      if (ay >= ax && ay >= az) begin
         r.col = pixel_coord(e, ay, -x);
         r.face = (y > 0) ? FACE_PY : FACE_NY;
         r.row = pixel_coord(e, ay, (y > 0) ? z : -z);
      end else if (ax >= az) begin
         r.row = pixel_coord(e, ax, -y);
         r.face = (x > 0) ? FACE_PX : FACE_NX;
         r.col = pixel_coord(e, ax, (x > 0) ? z : -z);
      end else begin
         r.row = pixel_coord(e, az, y);
         r.face = (z > 0) ? FACE_PZ : FACE_NZ;
         r.col = pixel_coord(e, az, (z > 0) ? -x : x);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         edge_reg <= 13'd1024;
         tilt_reg <= 16'd0;
         fail_count = 0;
         wr_count = 0;
         rd_count = 0;
      end else begin
         if (start && !busy) begin
            exp_mem[wr_count % DEPTH] = map_direction(req_latitude, req_longitude);
            wr_count++;
         end
         if (rsp_valid) begin
            if (wr_count == rd_count) report_mismatch("unexpected response", 1, 0);
            else begin
               want = exp_mem[rd_count % DEPTH];
               rd_count++;
               if (rsp_face !== want.face) report_mismatch("face", rsp_face, want.face);
               if (rsp_face_x !== want.col) report_mismatch("face_x", rsp_face_x, want.col);
               if (rsp_face_y !== want.row) report_mismatch("face_y", rsp_face_y, want.row);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_EDGE) edge_reg <= csr_data[12:0];
            else tilt_reg <= csr_data;
         end
      end
   end
endmodule

>>> bench/sphere_to_cube_face_map_test.sv
// Top of the cube face mapper bench: clock, reset, request and CSR stimulus, verdict.
// Depends on s2c_pkg, sphere_to_cube_face_map and sphere_to_cube_face_map_check.
`timescale 1ns / 100ps
module sphere_to_cube_face_map_test;
   import s2c_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_latitude = '0;
   logic [15:0] req_longitude = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_face;
   logic [11:0] rsp_face_x, rsp_face_y;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_EDGE;
   logic [15:0] csr_data = '0;
   int          fail_count, pending;

   always #4 clock = ~clock;

   sphere_to_cube_face_map dut (
      .clock, .reset, .start, .busy, .req_latitude, .req_longitude,
      .rsp_valid, .rsp_face, .rsp_face_x, .rsp_face_y,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   sphere_to_cube_face_map_check checker_i (
      .clock, .reset, .start, .busy, .req_latitude, .req_longitude,
      .rsp_valid, .rsp_face, .rsp_face_x, .rsp_face_y,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending
   );

   // mostly short pauses, a few long ones; start drops only for a real gap
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (n > 0) begin
         start <= 1'b0;
         req_latitude <= 16'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   // one request; start stays high when the next one follows directly
   task automatic send_point(input logic [15:0] lat, input logic [15:0] lon,
                             input bit gaps);
      start <= 1'b1;
      req_latitude <= lat;
      req_longitude <= lon;
      do @(posedge clock); while (busy);
      if (gaps && $urandom_range(0, 3) == 0) idle_gap();
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   // register writes only with the pipe empty; caller drops csr_valid
   task automatic write_reg(input logic idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   logic [15:0] edge_set[8] = '{16'd2, 16'd4096, 16'd1024, 16'd3, 16'd8191,
                                 16'd0, 16'd17, 16'd255};
   logic [15:0] tilt_set[8] = '{16'h8000, 16'h7fff, 16'd0, 16'd4096, 16'hf000,
                                 16'd1, 16'hffff, 16'h4000};
   logic [15:0] lat_dir[12] = '{16'h4000, 16'hc000, 16'd0, 16'h2000, 16'he000,
                                 16'h7fff, 16'h8000, 16'hffff, 16'd1, 16'h3fff,
                                 16'h5555, 16'haaaa};
   logic [15:0] lon_dir[12] = '{16'd0, 16'hffff, 16'h4000, 16'h8000, 16'hc000,
                                 16'h2000, 16'h6000, 16'd1, 16'h1fff, 16'ha000,
                                 16'h5555, 16'haaaa};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: poles, axis directions, face edges and corners, raw angles
      for (int i = 0; i < 12; i++) send_point(lat_dir[i], lon_dir[i], 1'b0);
      for (int i = 0; i < 8; i++)
         send_point(16'(16'h2000 * i), 16'(16'h2000 * (7 - i)), 1'b1);
      drain();
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_EDGE, edge_set[phase]);
         write_reg(CSR_TILT, tilt_set[phase]);
         csr_valid <= 1'b0;
         for (int i = 0; i < 70; i++) begin
            logic [15:0] lat;
            case ($urandom_range(0, 9))
               0: lat = 16'($urandom);
               1: lat = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
               default: lat = 16'(int'($urandom_range(0, 32768)) - 16384);
            endcase
            send_point(lat, 16'($urandom), 1'b1);
         end
         drain();
      end
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+hdl
hdl/s2c_pkg.sv
hdl/s2c_sin.sv
hdl/s2c_div_cell.sv
hdl/s2c_coord.sv
hdl/sphere_to_cube_face_map.sv
bench/sphere_to_cube_face_map_check.sv
bench/sphere_to_cube_face_map_test.sv
